// File: rtl/core/i2cbwf_pkg.sv
// Shared types and constants for the byte/word register file adapter.
package i2cbwf_pkg;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    localparam logic [5:0]  MAX_DRAIN  = 6'd63;
    localparam logic [3:0]  THR_RESET  = 4'd3;
    localparam logic [31:0] WORD_ONES  = 32'hffff_ffff;

    typedef enum logic [2:0] {
        REQ_WRITE  = 3'd0,
        REQ_DRAIN  = 3'd1,
        REQ_POST   = 3'd2,
        REQ_MREAD  = 3'd3,
        REQ_ZDEPTH = 3'd4,
        REQ_POLL   = 3'd5
    } t_req;

    typedef struct packed {
        t_req        kind;
        logic [7:0]  data;
        logic [5:0]  pos;
        logic        sda;
        logic        host;
    } t_cmd;

    typedef struct packed {
        t_req        kind;
        logic [7:0]  out_byte;
        logic [5:0]  byte_count;
        logic        is_last;
        logic        bus_stuck;
        logic [15:0] recovery_count;
    } t_res;

endpackage

// File: rtl/core/i2c_target_byte_word_fifo_adapter_top.sv
// Top level of the byte-access adapter for two word-stored circular register files.
//
// Requests enter on the s_t* stream (type in s_tuser); a request of a known type
// yields result transfers on the m_t* stream, tlast marking the final one.  A
// drain yields one per queued write-file byte, up to 63, or one empty transfer if
// none is queued; other types yield exactly one.  APB writes set the stall threshold.
// A two-entry command queue sits between the front end and the executing back
// end, so requests keep being accepted until it is full while a result waits on
// a stalled m_tready; the result register simply holds until taken.
// In the back end each request passes through the idle (pop), issue, wait and
// execute states, and execute holds while an earlier result still waits on
// m_tready; a drain goes back from execute to issue for each further byte, since
// every byte needs its own registered read of the write-file RAM.
// Request types six and seven are accepted and produce no transfer.
// Reset clears the pointers, counters and per-word valid flags of the read
// file; no clearing pass is needed, so the block is ready as soon as reset is
// released.  Write-file contents stay undefined until written.
module i2c_target_byte_word_fifo_adapter_top
    import i2cbwf_pkg::*;
#(
    parameter int FILE_BYTES = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // data_byte[7:0], byte_index[13:8], hw_read_ptr[19:14], sda_level[20], host_on[21]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // req_type[2:0]
    input  logic [2:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // out_byte[7:0], byte_count[13:8], bus_stuck[14], recovery_count[30:15]
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast,
    // resp_kind[2:0]
    output logic [2:0]           m_tuser,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic       w_thr_we;
    logic [3:0] r_thr_val;
    logic       w_cmd_vld;
    logic       w_cmd_pop;
    t_cmd       w_cmd;
    logic       w_out_vld;
    t_res       w_out;

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == 1'b0) ? {28'd0, r_thr_val} : 32'd0;
    assign w_thr_we = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_val <= THR_RESET;
        end else if (w_thr_we) begin
            r_thr_val <= pwdata[3:0];
        end
    end

    i2cbwf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_cmd_vld  (w_cmd_vld),
        .o_cmd      (w_cmd),
        .i_cmd_pop  (w_cmd_pop)
    );

    i2cbwf_back #(.FILE_BYTES(FILE_BYTES)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_vld  (w_cmd_vld),
        .i_cmd      (w_cmd),
        .o_cmd_pop  (w_cmd_pop),
        .i_thr      (r_thr_val),
        .o_out_vld  (w_out_vld),
        .o_out      (w_out),
        .i_m_tready (m_tready)
    );

    assign m_tvalid = w_out_vld;
    assign m_tlast  = w_out.is_last;
    assign m_tuser  = w_out.kind;
    assign m_tdata  = {1'b0, w_out.recovery_count, w_out.bus_stuck,
                       w_out.byte_count, w_out.out_byte};

`ifndef ASSERT_OFF
    a_stuck_on_poll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tdata[14]) |-> (m_tuser == REQ_POLL))
        else $error("bus_stuck set on a non-poll result");

    a_multi_on_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tlast) |-> (m_tuser == REQ_DRAIN))
        else $error("non-final result outside a drain");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser != REQ_DRAIN && m_tuser != REQ_MREAD)
        |-> (m_tdata[7:0] == 8'd0))
        else $error("out_byte nonzero on a result that carries no byte");
`endif

endmodule

// File: rtl/core/i2cbwf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module i2cbwf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/i2cbwf_front.sv
// Front end: accepts requests, drops unknown types and queues commands.
module i2cbwf_front
    import i2cbwf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic [2:0]           i_s_tuser,
    output logic                 o_cmd_vld,
    output t_cmd                 o_cmd,
    input  logic                 i_cmd_pop
);

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_known;
    logic       w_push;
    t_cmd       w_cmd;

    always_comb begin
        w_known    = i_s_tuser inside {[REQ_WRITE:REQ_POLL]};
        w_cmd.kind = t_req'(i_s_tuser);
        w_cmd.data = i_s_tdata[7:0];
        w_cmd.pos  = (i_s_tuser == REQ_MREAD) ? i_s_tdata[13:8] : i_s_tdata[19:14];
        w_cmd.sda  = i_s_tdata[20];
        w_cmd.host = i_s_tdata[21];
    end

    assign o_s_tready = (r_cnt != 2'd2);
    assign w_push     = i_s_tvalid && o_s_tready && w_known;
    assign o_cmd_vld  = (r_cnt != 2'd0);
    assign o_cmd      = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= w_cmd;
                r_wp      <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_cmd_pop};
        end
    end

endmodule

// File: rtl/core/i2cbwf_back.sv
// Back end: executes queued commands against the two register files.
module i2cbwf_back
    import i2cbwf_pkg::*;
#(
    parameter int FILE_BYTES = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_vld,
    input  t_cmd       i_cmd,
    output logic       o_cmd_pop,
    input  logic [3:0] i_thr,
    output logic       o_out_vld,
    output t_res       o_out,
    input  logic       i_m_tready
);

    localparam int PW = $clog2(FILE_BYTES);
    localparam int NW = (FILE_BYTES + 3) / 4;
    localparam int RW = ((PW > 6) ? PW : 6) + 1;
    localparam logic [PW-1:0] LAST_POS = PW'(FILE_BYTES - 1);
    localparam logic [RW-1:0] FB_R     = RW'(FILE_BYTES);

    typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_EXEC} t_state;

    t_state        r_state, n_state;
    t_cmd          r_cmd, n_cmd;
    logic [5:0]    r_cnt, n_cnt;
    logic [5:0]    r_left, n_left;
    logic [PW-1:0] r_mptr, n_mptr;
    logic [PW-1:0] r_cptr, n_cptr;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [3:0]    r_low, n_low;
    logic [15:0]   r_rec, n_rec;
    logic [NW-1:0] r_rf_vld, n_rf_vld;
    logic          r_rd_vld, n_rd_vld;
    logic          r_rd_w0, n_rd_w0;
    logic [PW-1:0] r_addr, n_addr;
    t_res          r_out, n_out;
    logic          r_out_vld, n_out_vld;

    logic          wf_re, wf_we, rf_re, rf_we;
    logic [31:0]   wf_q, rf_q, w_rf_word, w_word, w_wdata;
    logic [7:0]    w_byte;
    logic [PW-1:0] w_pos;
    logic [RW-1:0] w_red, w_dist_drain, w_dist_rd;
    logic [5:0]    w_drain_n;
    logic [3:0]    w_low_inc;
    logic          w_out_free;
    logic          w_last;

    function automatic logic [PW-1:0] f_inc(input logic [PW-1:0] p);
        return (p == LAST_POS) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [RW-1:0] f_dist(input logic [PW-1:0] to_p,
                                             input logic [PW-1:0] from_p);
        logic [RW-1:0] s;
        s = RW'(to_p) + FB_R - RW'(from_p);
        if (s >= FB_R) begin
            s = s - FB_R;
        end
        return s;
    endfunction

    i2cbwf_ram #(.WIDTH(32), .DEPTH(NW)) u_wfile (
        .i_clk   (i_clk),
        .i_we    (wf_we),
        .i_waddr (r_addr[PW-1:2]),
        .i_wdata (w_wdata),
        .i_re    (wf_re),
        .i_raddr (n_addr[PW-1:2]),
        .o_rdata (wf_q)
    );

    i2cbwf_ram #(.WIDTH(32), .DEPTH(NW)) u_rfile (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (r_addr[PW-1:2]),
        .i_wdata (w_wdata),
        .i_re    (rf_re),
        .i_raddr (n_addr[PW-1:2]),
        .o_rdata (rf_q)
    );

    always_comb begin
        w_red = RW'(r_cmd.pos);
        for (int k = 0; k < 8; k++) begin
            if (w_red >= FB_R) begin
                w_red = w_red - FB_R;
            end
        end
        w_pos = w_red[PW-1:0];
    end

    always_comb begin
        w_dist_drain = f_dist(r_mptr, r_cptr);
        w_drain_n    = (w_dist_drain > RW'(MAX_DRAIN)) ? MAX_DRAIN : w_dist_drain[5:0];
        w_dist_rd    = f_dist(r_rptr, w_pos);
        w_rf_word    = r_rd_vld ? rf_q : (r_rd_w0 ? WORD_ONES : '0);
        w_word       = (r_cmd.kind == REQ_WRITE || r_cmd.kind == REQ_DRAIN) ? wf_q : w_rf_word;
        w_byte       = w_word[8*r_addr[1:0] +: 8];
        w_wdata      = w_word;
        w_wdata[8*r_addr[1:0] +: 8] = r_cmd.data;
        w_out_free   = !r_out_vld || i_m_tready;
        w_low_inc    = r_low + 4'd1;
        w_last       = ((r_cnt + 6'd1) == r_left);
    end

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_cnt     = r_cnt;
        n_left    = r_left;
        n_mptr    = r_mptr;
        n_cptr    = r_cptr;
        n_rptr    = r_rptr;
        n_low     = r_low;
        n_rec     = r_rec;
        n_rf_vld  = r_rf_vld;
        n_rd_vld  = r_rd_vld;
        n_rd_w0   = r_rd_w0;
        n_addr    = r_addr;
        n_out     = r_out;
        n_out_vld = r_out_vld && !i_m_tready;
        o_cmd_pop = 1'b0;
        wf_re     = 1'b0;
        wf_we     = 1'b0;
        rf_re     = 1'b0;
        rf_we     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_vld) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_cnt     = '0;
                    n_state   = S_ISSUE;
                end
            end
            S_ISSUE: begin
                n_state = S_WAIT;
                case (r_cmd.kind)
                    REQ_WRITE: begin
                        n_addr = r_mptr;
                        wf_re  = 1'b1;
                    end
                    REQ_DRAIN: begin
                        n_addr = r_cptr;
                        wf_re  = 1'b1;
                        if (r_cnt == '0) begin
                            n_left = w_drain_n;
                            n_low  = '0;
                        end
                    end
                    REQ_POST: begin
                        n_addr = r_rptr;
                        rf_re  = 1'b1;
                    end
                    REQ_MREAD: begin
                        n_addr = w_pos;
                        rf_re  = 1'b1;
                    end
                    default: begin
                    end
                endcase
                n_rd_vld = r_rf_vld[n_addr[PW-1:2]];
                n_rd_w0  = (n_addr[PW-1:2] == '0);
            end
            S_WAIT: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_state              = S_IDLE;
                    n_out_vld            = 1'b1;
                    n_out.kind           = r_cmd.kind;
                    n_out.out_byte       = '0;
                    n_out.byte_count     = '0;
                    n_out.is_last        = 1'b1;
                    n_out.bus_stuck      = 1'b0;
                    case (r_cmd.kind)
                        REQ_WRITE: begin
                            wf_we  = 1'b1;
                            n_mptr = f_inc(r_mptr);
                        end
                        REQ_DRAIN: begin
                            if (r_left != '0) begin
                                n_out.out_byte   = w_byte;
                                n_out.byte_count = r_cnt + 6'd1;
                                n_out.is_last    = w_last;
                                n_cptr           = f_inc(r_cptr);
                                if (!w_last) begin
                                    n_cnt   = r_cnt + 6'd1;
                                    n_state = S_ISSUE;
                                end
                            end
                        end
                        REQ_POST: begin
                            rf_we                    = 1'b1;
                            n_rf_vld[r_addr[PW-1:2]] = 1'b1;
                            n_rptr                   = f_inc(r_rptr);
                        end
                        REQ_MREAD: begin
                            n_out.out_byte = w_byte;
                        end
                        REQ_ZDEPTH: begin
                            n_out.byte_count = w_dist_rd[5:0];
                            if (w_dist_rd != '0) begin
                                n_rptr = w_pos;
                            end
                        end
                        REQ_POLL: begin
                            if (!r_cmd.host || r_cmd.sda) begin
                                n_low = '0;
                            end else if (w_low_inc >= i_thr) begin
                                n_low           = '0;
                                n_rec           = r_rec + 16'd1;
                                n_rptr          = '0;
                                n_cptr          = '0;
                                n_mptr          = '0;
                                n_rf_vld[0]     = 1'b0;
                                n_out.bus_stuck = 1'b1;
                            end else begin
                                n_low = w_low_inc;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_out.recovery_count = n_rec;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_left    <= '0;
            r_mptr    <= '0;
            r_cptr    <= '0;
            r_rptr    <= '0;
            r_low     <= '0;
            r_rec     <= '0;
            r_rf_vld  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_left    <= n_left;
            r_mptr    <= n_mptr;
            r_cptr    <= n_cptr;
            r_rptr    <= n_rptr;
            r_low     <= n_low;
            r_rec     <= n_rec;
            r_rf_vld  <= n_rf_vld;
            r_out_vld <= n_out_vld;
            r_cmd     <= n_cmd;
            r_rd_vld  <= n_rd_vld;
            r_rd_w0   <= n_rd_w0;
            r_addr    <= n_addr;
            r_out     <= n_out;
        end
    end

    assign o_out_vld = r_out_vld;
    assign o_out     = r_out;

endmodule
